// File: hdl/wpr_pkg.sv
// Shared package of the waveform preview resampler.
// Widths, mode codes and the command/status bundles between controller and datapath.
// No dependencies.
package wpr_pkg;

   localparam int COUNT_W     = 16;               // in_count, out_count and run counters
   localparam int SAMPLE_W    = 16;               // PCM sample and preview value
   localparam int SUM_W       = 32;               // magnitude accumulator, divider dividend
   localparam int MAX_REPEAT  = 64;               // out_count is clamped to MAX_REPEAT * in_count
   localparam int MAX_RESULTS = 64;               // most values one sample may give
   localparam int REP_W       = $clog2(MAX_RESULTS + 1);
   localparam int CAP_W       = COUNT_W + $clog2(MAX_REPEAT + 1);
   localparam int REM_W       = COUNT_W + 1;      // boundary remainder
   localparam int CSR_IDX_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_EQUAL   = 2'd1,
      MODE_SHRINK  = 2'd2,
      MODE_STRETCH = 2'd3
   } mode_type;

   typedef struct packed {
      logic ratio_load;   // latch run geometry, start ratio divide
      logic ratio_take;   // latch quotient and remainder of the ratio
      logic take_item;    // capture a sample transfer
      logic advance;      // accumulate, step the candidate boundary
      logic find_end;     // round and clip the candidate boundary
      logic plan_reps;    // commit boundary, load repeat count
      logic mean_start;   // start the batch mean divide
      logic mean_emit;    // hand the mean to the output register
      logic rep_emit;     // hand one repeated magnitude to the output register
      logic finish;       // close the run after its last sample
   } cmd_type;

   typedef struct packed {
      logic     div_done;
      logic     out_free;
      logic     mean_due;
      logic     reps_left;
      mode_type mode;
   } status_type;

endpackage

// File: hdl/wpr_divider.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Divides the ratio of the counts and the batch magnitude sum.
// Depends on wpr_pkg.
module wpr_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wpr_pkg::SUM_W-1:0]    dividend,
   input  logic [wpr_pkg::COUNT_W-1:0]  divisor,
   output logic                         done,
   output logic [wpr_pkg::SUM_W-1:0]    quotient,
   output logic [wpr_pkg::COUNT_W-1:0]  remainder
);
   import wpr_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [COUNT_W:0]   shifted;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? COUNT_W'(shifted - {1'b0, dvs_ff}) : shifted[COUNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/wpr_datapath.sv
// Datapath of the waveform preview resampler: count registers, run state,
// exact boundary tracking, batch accumulation and the output register.
// Depends on wpr_pkg and wpr_divider.
module wpr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  wpr_pkg::cmd_type                cmd,
   output wpr_pkg::status_type             status,
   input  logic                            csr_write,
   input  logic [wpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wpr_pkg::COUNT_W-1:0]     csr_data,
   input  logic [wpr_pkg::SAMPLE_W-1:0]    sample,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wpr_pkg::SAMPLE_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast
);
   import wpr_pkg::*;

   // configuration and run geometry
   logic [COUNT_W-1:0]  in_count_ff, in_count_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic [COUNT_W-1:0]  m_ff, m_in;
   logic [COUNT_W-1:0]  lng_ff, lng_in;
   logic [COUNT_W-1:0]  sht_ff, sht_in;
   mode_type            mode_ff, mode_in;
   logic [COUNT_W-1:0]  q_ff, q_in;
   logic [COUNT_W-1:0]  r_ff, r_in;
   // run state
   logic [COUNT_W-1:0]  it_ff, it_in;
   logic [COUNT_W-1:0]  og_ff, og_in;
   logic [COUNT_W-1:0]  bpos_ff, bpos_in;
   logic [REM_W-1:0]    brem_ff, brem_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  blen_ff, blen_in;
   logic [REP_W-1:0]    reps_ff, reps_in;
   // per item
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [REM_W-1:0]    cand_pos_ff, cand_pos_in;
   logic [REM_W-1:0]    cand_rem_ff, cand_rem_in;
   logic [COUNT_W-1:0]  bound_end_ff, bound_end_in;
   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [CAP_W-1:0]    cap_c;
   logic [COUNT_W-1:0]  m_c, lng_c, sht_c;
   mode_type            mode_c;
   logic [SAMPLE_W-1:0] mag_c;
   logic [REM_W-1:0]    pos_sum, pos_sum_inc, rem_sum;
   logic [REM_W:0]      rem_wrap;
   logic [REM_W:0]      end_raw;
   logic [REM_W-1:0]    gap;
   logic [COUNT_W-1:0]  og_inc;
   logic                out_free;

   logic                div_start, div_done;
   logic [SUM_W-1:0]    div_dividend, div_quo;
   logic [COUNT_W-1:0]  div_divisor, div_rem;

   // effective out_count and which side is longer
   assign cap_c = CAP_W'(in_count_ff) * CAP_W'(MAX_REPEAT);
   assign m_c   = (CAP_W'(out_count_ff) > cap_c) ? cap_c[COUNT_W-1:0] : out_count_ff;

   always_comb begin
      if (in_count_ff == '0 || m_c == '0) begin
         mode_c = MODE_NONE;
      end else if (in_count_ff > m_c) begin
         mode_c = MODE_SHRINK;
      end else if (in_count_ff < m_c) begin
         mode_c = MODE_STRETCH;
      end else begin
         mode_c = MODE_EQUAL;
      end
   end

   assign lng_c = (mode_c == MODE_SHRINK) ? in_count_ff : m_c;
   assign sht_c = (mode_c == MODE_SHRINK) ? m_c : in_count_ff;

   // magnitude; the most negative sample wraps onto itself
   assign mag_c = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

   // candidate boundary: previous one plus quotient and remainder of L/S
   assign pos_sum     = {1'b0, bpos_ff} + {1'b0, q_ff};
   assign pos_sum_inc = pos_sum + REM_W'(1);
   assign rem_sum     = brem_ff + {1'b0, r_ff};
   assign rem_wrap    = {1'b0, rem_sum} - (REM_W + 1)'(sht_ff);

   // round half up, clip to the longer side
   assign end_raw = {1'b0, cand_pos_ff}
                  + (REM_W + 1)'({cand_rem_ff, 1'b0} >= (REM_W + 1)'(sht_ff));

   assign gap      = {1'b0, bound_end_ff} - {1'b0, og_ff};
   assign og_inc   = og_ff + COUNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign div_start    = cmd.ratio_load || cmd.mean_start;
   assign div_dividend = cmd.ratio_load ? SUM_W'(lng_c) : sum_ff;
   assign div_divisor  = cmd.ratio_load ? sht_c : blen_ff;

   wpr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      m_in         = m_ff;
      lng_in       = lng_ff;
      sht_in       = sht_ff;
      mode_in      = mode_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      it_in        = it_ff;
      og_in        = og_ff;
      bpos_in      = bpos_ff;
      brem_in      = brem_ff;
      sum_in       = sum_ff;
      blen_in      = blen_ff;
      reps_in      = reps_ff;
      mag_in       = mag_ff;
      cand_pos_in  = cand_pos_ff;
      cand_rem_in  = cand_rem_ff;
      bound_end_in = bound_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.ratio_load) begin
         m_in    = m_c;
         lng_in  = lng_c;
         sht_in  = sht_c;
         mode_in = mode_c;
      end

      if (cmd.ratio_take) begin
         q_in = div_quo[COUNT_W-1:0];
         r_in = div_rem;
      end

      if (cmd.take_item) begin
         mag_in = mag_c;
         if (mode_ff != MODE_NONE) begin
            it_in = it_ff + COUNT_W'(1);
         end
      end

      if (cmd.advance) begin
         if (mode_ff == MODE_SHRINK) begin
            sum_in  = sum_ff + SUM_W'(mag_ff);
            blen_in = blen_ff + COUNT_W'(1);
         end
         if (!rem_wrap[REM_W]) begin
            cand_rem_in = rem_wrap[REM_W-1:0];
            cand_pos_in = pos_sum_inc;
         end else begin
            cand_rem_in = rem_sum;
            cand_pos_in = pos_sum;
         end
      end

      if (cmd.find_end) begin
         bound_end_in = (end_raw > (REM_W + 1)'(lng_ff)) ? lng_ff : end_raw[COUNT_W-1:0];
      end

      if (cmd.plan_reps) begin
         bpos_in = cand_pos_ff[COUNT_W-1:0];
         brem_in = cand_rem_ff;
         if (bound_end_ff <= og_ff) begin
            reps_in = '0;
         end else if (gap > REM_W'(MAX_RESULTS)) begin
            reps_in = REP_W'(MAX_RESULTS);
         end else begin
            reps_in = gap[REP_W-1:0];
         end
      end

      if (cmd.mean_emit) begin
         bpos_in      = cand_pos_ff[COUNT_W-1:0];
         brem_in      = cand_rem_ff;
         og_in        = og_inc;
         sum_in       = '0;
         blen_in      = '0;
         rsp_valid_in = 1'b1;
         rsp_value_in = div_quo[SAMPLE_W-1:0];
         rsp_last_in  = (og_inc == m_ff);
      end

      if (cmd.rep_emit) begin
         og_in        = og_inc;
         reps_in      = reps_ff - REP_W'(1);
         rsp_valid_in = 1'b1;
         rsp_value_in = mag_ff;
         rsp_last_in  = (og_inc == m_ff);
      end

      // end of run, or a write to either count register: start a fresh run
      if ((cmd.finish && it_ff == in_count_ff) ||
          (csr_write && (csr_index == CSR_IN_COUNT || csr_index == CSR_OUT_COUNT))) begin
         it_in   = '0;
         og_in   = '0;
         bpos_in = '0;
         brem_in = '0;
         sum_in  = '0;
         blen_in = '0;
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_IN_COUNT:  in_count_in  = csr_data;
            CSR_OUT_COUNT: out_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= COUNT_W'(1);
         out_count_ff <= COUNT_W'(1);
         mode_ff      <= MODE_NONE;
         it_ff        <= '0;
         og_ff        <= '0;
         bpos_ff      <= '0;
         brem_ff      <= '0;
         sum_ff       <= '0;
         blen_ff      <= '0;
         reps_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         mode_ff      <= mode_in;
         it_ff        <= it_in;
         og_ff        <= og_in;
         bpos_ff      <= bpos_in;
         brem_ff      <= brem_in;
         sum_ff       <= sum_in;
         blen_ff      <= blen_in;
         reps_ff      <= reps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      lng_ff       <= lng_in;
      sht_ff       <= sht_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      mag_ff       <= mag_in;
      cand_pos_ff  <= cand_pos_in;
      cand_rem_ff  <= cand_rem_in;
      bound_end_ff <= bound_end_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.div_done  = div_done;
   assign status.out_free  = out_free;
   assign status.mean_due  = (it_ff >= bound_end_ff) && (blen_ff != '0);
   assign status.reps_left = (reps_ff != '0);
   assign status.mode      = mode_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // committed remainder stays below the shorter count
   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SHRINK || mode_ff == MODE_STRETCH) |-> brem_ff < REM_W'(sht_ff))
      else $error("boundary remainder reached the shorter count");

   // never more preview values than the effective out_count
   a_outputs_bounded: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SHRINK || mode_ff == MODE_STRETCH) |-> og_ff <= m_ff)
      else $error("more preview values given than out_count");
`endif

endmodule

// File: hdl/wpr_ctrl.sv
// Controller of the waveform preview resampler: sequences ratio set-up,
// sample steps, divider use and value emission. Depends on wpr_pkg.
module wpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  wpr_pkg::status_type  status,
   output wpr_pkg::cmd_type     cmd
);
   import wpr_pkg::*;

   typedef enum logic [9:0] {
      ST_RSTART     = 10'b0000000001,
      ST_RWAIT      = 10'b0000000010,
      ST_IDLE       = 10'b0000000100,
      ST_ADV        = 10'b0000001000,
      ST_END        = 10'b0000010000,
      ST_DECIDE     = 10'b0000100000,
      ST_MEAN_START = 10'b0001000000,
      ST_MEAN_WAIT  = 10'b0010000000,
      ST_EMIT       = 10'b0100000000,
      ST_FINISH     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      csr_write;
   logic      req_take;

   assign csr_ready  = (state_ff == ST_IDLE) || (state_ff == ST_RSTART) ||
                       (state_ff == ST_RWAIT);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_write  = csr_valid && csr_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_RSTART: begin
            // a write here changes the counts under the divide: redo the set-up
            cmd.ratio_load = 1'b1;
            state_in       = csr_write ? ST_RSTART : ST_RWAIT;
         end
         ST_RWAIT: begin
            if (csr_write) begin
               state_in = ST_RSTART;
            end else if (status.div_done) begin
               cmd.ratio_take = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_write) begin
               state_in = ST_RSTART;
            end else if (req_take) begin
               cmd.take_item = 1'b1;
               state_in      = (status.mode == MODE_NONE) ? ST_IDLE : ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = (status.mode == MODE_EQUAL) ? ST_FINISH : ST_END;
         end
         ST_END: begin
            cmd.find_end = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.mode == MODE_STRETCH) begin
               cmd.plan_reps = 1'b1;
               state_in      = ST_EMIT;
            end else if (status.mean_due) begin
               state_in = ST_MEAN_START;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MEAN_START: begin
            cmd.mean_start = 1'b1;
            state_in       = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done && status.out_free) begin
               cmd.mean_emit = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_EMIT: begin
            if (!status.reps_left) begin
               state_in = ST_FINISH;
            end else if (status.out_free) begin
               cmd.rep_emit = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_RSTART;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RSTART;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a register write always recomputes the ratio
   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> state_ff == ST_RSTART)
      else $error("register write did not restart the ratio set-up");

   // samples are taken only once the divider holds a finished result
   a_take_after_ratio: assert property (@(posedge clock) disable iff (reset)
      req_take |-> status.div_done)
      else $error("sample taken while the divider was busy");

   // a value is only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.mean_emit || cmd.rep_emit) |-> status.out_free)
      else $error("value loaded over an unaccepted result");
`endif

endmodule

// File: hdl/waveform_preview_resampler_top.sv
// Waveform preview resampler, top level.
// Depends on wpr_pkg, wpr_ctrl and wpr_datapath (with wpr_divider).
//  - Write in_count (index 0) and out_count (index 1) on the csr_ channel while
//    the block is idle; each write starts a new run. The ratio of the counts is
//    then set up on the shared divider before samples are taken.
//  - Stream in_count samples on req_; after the last one the run restarts by itself.
//  - Preview values leave on rsp_, rsp_tlast marking the final value of the run.
//    Shrinking gives one truncated mean of magnitudes per batch, stretching
//    repeats each magnitude over its batch, equal counts give nothing.
//  - Samples: one sample is worked at a time. A shrink sample that closes a
//    batch also waits for the mean divide (32-step divider), a stretched sample
//    for each repeated value; equal counts and a zero count do neither.
//  - The first value of a sample is registered on rsp_ after the advance, end,
//    decide and emit states when stretching, after the mean divide when shrinking.
//  - A stalled receiver holds the output register; the controller waits for it
//    before loading another value, and the next sample may already be taken
//    while the last result waits.
//  - Reset (synchronous, active high) sets both counts to 1, clears the run and
//    runs the ratio set-up before the first sample is accepted.
module waveform_preview_resampler_top (
   input  logic                            clock,
   input  logic                            reset,
   // sample input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wpr_pkg::SAMPLE_W-1:0]    req_tdata,   // [15:0] sample
   // preview output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wpr_pkg::SAMPLE_W-1:0]    rsp_tdata,   // [15:0] value
   output logic                            rsp_tlast,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wpr_pkg::COUNT_W-1:0]     csr_data
);
   import wpr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // a register transfer updates the datapath in the same edge the controller sees it
   assign csr_write = csr_valid && csr_ready;

   wpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wpr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample     (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
